>>> sv/tgab_pkg.sv
// ----------------------------------------------------------------------------
// Tanner graph adjacency builder package
// Field widths, default sizes, operation, error, register and state codes.
// ----------------------------------------------------------------------------
package tgab_pkg;

   localparam int MAX_ROWS_DEF              = 256;
   localparam int MAX_COLS_DEF              = 512;
   localparam int CHECK_DEGREE_LIMIT_DEF    = 16;
   localparam int VARIABLE_DEGREE_LIMIT_DEF = 8;

   localparam int OP_W       = 2;
   localparam int ROW_W      = 8;
   localparam int COL_W      = 9;
   localparam int SLOT_W     = 4;
   localparam int NEIGHBOR_W = 9;
   localparam int CDEG_W     = 5;
   localparam int VDEG_W     = 4;
   localparam int ERROR_W    = 3;
   localparam int CSR_IDX_W  = 1;
   localparam int CSR_DATA_W = 10;
   localparam int NCHK_W     = 9;
   localparam int NVAR_W     = 10;

   localparam logic [NCHK_W-1:0] NUM_CHECKS_RST    = NCHK_W'(256);
   localparam logic [NVAR_W-1:0] NUM_VARIABLES_RST = NVAR_W'(512);

   typedef enum logic [OP_W-1:0] {
      OP_ENTRY      = 2'd0,
      OP_READ_CHECK = 2'd1,
      OP_READ_VAR   = 2'd2,
      OP_CLEAR      = 2'd3
   } op_type;

   typedef enum logic [ERROR_W-1:0] {
      ERR_NONE       = 3'd0,
      ERR_RANGE      = 3'd1,
      ERR_CHECK_FULL = 3'd2,
      ERR_VAR_FULL   = 3'd3,
      ERR_SLOT       = 3'd4
   } err_type;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_NUM_CHECKS    = 1'b0,
      CSR_NUM_VARIABLES = 1'b1
   } csr_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_EXEC,
      ST_CLEAR
   } state_type;

endpackage

>>> sv/tanner_graph_adjacency_builder_core.sv
// ----------------------------------------------------------------------------
// Tanner graph adjacency builder core
// Builds check-node and variable-node neighbor lists from parity-check
// matrix entries, and reads back single list slots.
// ----------------------------------------------------------------------------
// In the cycle in which start is taken the block reads both degree memories
// and both list memories, and in the next cycle it checks, writes back and
// registers the result, which shows on the rsp_ ports with rsp_valid for one
// cycle while a new start can already be taken (not after a clear). Busy is
// high while a transaction executes, so a new start waits until the degree
// memories, which have a registered read, are written back. The receiver
// cannot stall, so a result must be taken in the cycle it is shown. After
// reset, and after each clear operation, the block sweeps both degree memories
// with zeros over max(MAX_ROWS, MAX_COLS) addresses (512 at the default sizes)
// with busy high; configuration writes are taken during the sweep.
// ----------------------------------------------------------------------------
module tanner_graph_adjacency_builder_core #(
   parameter int MAX_ROWS              = tgab_pkg::MAX_ROWS_DEF,
   parameter int MAX_COLS              = tgab_pkg::MAX_COLS_DEF,
   parameter int CHECK_DEGREE_LIMIT    = tgab_pkg::CHECK_DEGREE_LIMIT_DEF,
   parameter int VARIABLE_DEGREE_LIMIT = tgab_pkg::VARIABLE_DEGREE_LIMIT_DEF
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                start,
   output logic                                busy,
   input  logic [tgab_pkg::OP_W-1:0]           req_op,
   input  logic [tgab_pkg::ROW_W-1:0]          req_row,
   input  logic [tgab_pkg::COL_W-1:0]          req_col,
   input  logic                                req_bit_req,
   input  logic [tgab_pkg::SLOT_W-1:0]         req_slot,
   output logic                                rsp_valid,
   output logic [tgab_pkg::NEIGHBOR_W-1:0]     rsp_neighbor,
   output logic [tgab_pkg::CDEG_W-1:0]         rsp_check_degree,
   output logic [tgab_pkg::VDEG_W-1:0]         rsp_variable_degree,
   output logic [tgab_pkg::ERROR_W-1:0]        rsp_error,
   input  logic                                csr_we,
   input  logic [tgab_pkg::CSR_IDX_W-1:0]      csr_index,
   input  logic [tgab_pkg::CSR_DATA_W-1:0]     csr_wdata
);

   import tgab_pkg::*;

   localparam int RAW       = $clog2(MAX_ROWS);
   localparam int CAW       = $clog2(MAX_COLS);
   localparam int CDW       = $clog2(CHECK_DEGREE_LIMIT + 1);
   localparam int VDW       = $clog2(VARIABLE_DEGREE_LIMIT + 1);
   localparam int CL_DEPTH  = MAX_ROWS * CHECK_DEGREE_LIMIT;
   localparam int VL_DEPTH  = MAX_COLS * VARIABLE_DEGREE_LIMIT;
   localparam int CLAW      = $clog2(CL_DEPTH);
   localparam int VLAW      = $clog2(VL_DEPTH);
   localparam int CLR_DEPTH = (MAX_ROWS > MAX_COLS) ? MAX_ROWS : MAX_COLS;
   localparam int CLRW      = $clog2(CLR_DEPTH);

   state_type state_ff, state_in;

   op_type                   op_ff;
   logic [ROW_W-1:0]         row_ff;
   logic [COL_W-1:0]         col_ff;
   logic                     bit_ff;
   logic [SLOT_W-1:0]        slot_ff;

   logic [NCHK_W-1:0]        num_checks_ff, num_checks_in;
   logic [NVAR_W-1:0]        num_variables_ff, num_variables_in;
   logic [CLRW-1:0]          clr_cnt_ff, clr_cnt_in;

   logic                     rsp_valid_ff, rsp_valid_in;
   logic [NEIGHBOR_W-1:0]    rsp_neighbor_ff, rsp_neighbor_in;
   logic [CDEG_W-1:0]        rsp_cdeg_ff, rsp_cdeg_in;
   logic [VDEG_W-1:0]        rsp_vdeg_ff, rsp_vdeg_in;
   logic [ERROR_W-1:0]       rsp_error_ff, rsp_error_in;

   logic                     cdeg_we, vdeg_we, clist_we, vlist_we;
   logic [RAW-1:0]           cdeg_waddr, cdeg_raddr;
   logic [CAW-1:0]           vdeg_waddr, vdeg_raddr;
   logic [CDW-1:0]           cdeg_wdata, cdeg_rdata;
   logic [VDW-1:0]           vdeg_wdata, vdeg_rdata;
   logic [CLAW-1:0]          clist_waddr, clist_raddr;
   logic [VLAW-1:0]          vlist_waddr, vlist_raddr;
   logic [COL_W-1:0]         clist_rdata;
   logic [ROW_W-1:0]         vlist_rdata;

   logic [31:0]              req_row32, req_col32, row32, col32, clr32;
   logic [31:0]              clist_ra32, vlist_ra32, clist_wa32, vlist_wa32;
   logic [31:0]              cdeg_out32, vdeg_out32;
   logic                     row_ok, col_ok, commit;
   logic [CDW-1:0]           cdeg_next;
   logic [VDW-1:0]           vdeg_next;
   logic                     clr_last;

   // Read addresses come straight from the request ports in the accept cycle.
   assign req_row32   = 32'(req_row);
   assign req_col32   = 32'(req_col);
   assign clist_ra32  = req_row32 * CHECK_DEGREE_LIMIT + 32'(req_slot);
   assign vlist_ra32  = req_col32 * VARIABLE_DEGREE_LIMIT + 32'(req_slot);
   assign cdeg_raddr  = req_row32[RAW-1:0];
   assign vdeg_raddr  = req_col32[CAW-1:0];
   assign clist_raddr = clist_ra32[CLAW-1:0];
   assign vlist_raddr = vlist_ra32[VLAW-1:0];

   assign row32      = 32'(row_ff);
   assign col32      = 32'(col_ff);
   assign clr32      = 32'(clr_cnt_ff);
   assign clist_wa32 = row32 * CHECK_DEGREE_LIMIT + 32'(cdeg_rdata);
   assign vlist_wa32 = col32 * VARIABLE_DEGREE_LIMIT + 32'(vdeg_rdata);
   assign clr_last   = (clr32 == 32'(CLR_DEPTH - 1));

   assign row_ok = (row32 < 32'(num_checks_ff)) && (row32 < 32'(MAX_ROWS));
   assign col_ok = (col32 < 32'(num_variables_ff)) && (col32 < 32'(MAX_COLS));

   assign cdeg_next = cdeg_rdata + CDW'(1);
   assign vdeg_next = vdeg_rdata + VDW'(1);

   tgab_ram #(.WIDTH(CDW), .DEPTH(MAX_ROWS)) u_cdeg (
      .clock (clock),
      .we    (cdeg_we),
      .waddr (cdeg_waddr),
      .wdata (cdeg_wdata),
      .raddr (cdeg_raddr),
      .rdata (cdeg_rdata)
   );

   tgab_ram #(.WIDTH(VDW), .DEPTH(MAX_COLS)) u_vdeg (
      .clock (clock),
      .we    (vdeg_we),
      .waddr (vdeg_waddr),
      .wdata (vdeg_wdata),
      .raddr (vdeg_raddr),
      .rdata (vdeg_rdata)
   );

   tgab_ram #(.WIDTH(COL_W), .DEPTH(CL_DEPTH)) u_clist (
      .clock (clock),
      .we    (clist_we),
      .waddr (clist_waddr),
      .wdata (col_ff),
      .raddr (clist_raddr),
      .rdata (clist_rdata)
   );

   tgab_ram #(.WIDTH(ROW_W), .DEPTH(VL_DEPTH)) u_vlist (
      .clock (clock),
      .we    (vlist_we),
      .waddr (vlist_waddr),
      .wdata (row_ff),
      .raddr (vlist_raddr),
      .rdata (vlist_rdata)
   );

   // Result of the transaction under execution.
   always_comb begin
      rsp_neighbor_in = '0;
      rsp_error_in    = ERR_NONE;
      commit          = 1'b0;
      cdeg_out32      = 32'(cdeg_rdata);
      vdeg_out32      = 32'(vdeg_rdata);
      case (op_ff)
         OP_ENTRY: begin
            if (!row_ok || !col_ok) begin
               rsp_error_in = ERR_RANGE;
            end else if (bit_ff) begin
               if (32'(cdeg_rdata) >= 32'(CHECK_DEGREE_LIMIT)) begin
                  rsp_error_in = ERR_CHECK_FULL;
               end else if (32'(vdeg_rdata) >= 32'(VARIABLE_DEGREE_LIMIT)) begin
                  rsp_error_in = ERR_VAR_FULL;
               end else begin
                  commit     = 1'b1;
                  cdeg_out32 = 32'(cdeg_next);
                  vdeg_out32 = 32'(vdeg_next);
               end
            end
         end
         OP_READ_CHECK: begin
            if (!row_ok) begin
               rsp_error_in = ERR_RANGE;
            end else if (32'(slot_ff) >= 32'(cdeg_rdata)) begin
               rsp_error_in = ERR_SLOT;
            end else begin
               rsp_neighbor_in = clist_rdata;
            end
         end
         OP_READ_VAR: begin
            if (!col_ok) begin
               rsp_error_in = ERR_RANGE;
            end else if (32'(slot_ff) >= 32'(vdeg_rdata)) begin
               rsp_error_in = ERR_SLOT;
            end else begin
               rsp_neighbor_in = NEIGHBOR_W'(vlist_rdata);
            end
         end
         OP_CLEAR: begin
            cdeg_out32 = '0;
            vdeg_out32 = '0;
         end
         default: begin
            rsp_error_in = ERR_NONE;
         end
      endcase
      rsp_cdeg_in = row_ok ? cdeg_out32[CDEG_W-1:0] : '0;
      rsp_vdeg_in = col_ok ? vdeg_out32[VDEG_W-1:0] : '0;
   end

   // Next state.
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_IDLE: begin
            if (start) begin
               state_in = ST_EXEC;
            end
         end
         ST_EXEC: begin
            state_in = (op_ff == OP_CLEAR) ? ST_CLEAR : ST_IDLE;
         end
         ST_CLEAR: begin
            if (clr_last) begin
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   // Memory writes, busy, response strobe and sweep counter.
   always_comb begin
      busy         = 1'b1;
      rsp_valid_in = 1'b0;
      clr_cnt_in   = '0;
      cdeg_we      = 1'b0;
      vdeg_we      = 1'b0;
      clist_we     = 1'b0;
      vlist_we     = 1'b0;
      cdeg_waddr   = row32[RAW-1:0];
      vdeg_waddr   = col32[CAW-1:0];
      cdeg_wdata   = cdeg_next;
      vdeg_wdata   = vdeg_next;
      clist_waddr  = clist_wa32[CLAW-1:0];
      vlist_waddr  = vlist_wa32[VLAW-1:0];
      case (state_ff)
         ST_IDLE: begin
            busy = 1'b0;
         end
         ST_EXEC: begin
            rsp_valid_in = 1'b1;
            cdeg_we      = commit;
            vdeg_we      = commit;
            clist_we     = commit;
            vlist_we     = commit;
         end
         ST_CLEAR: begin
            clr_cnt_in = clr_cnt_ff + CLRW'(1);
            cdeg_we    = (clr32 < 32'(MAX_ROWS));
            vdeg_we    = (clr32 < 32'(MAX_COLS));
            cdeg_waddr = clr32[RAW-1:0];
            vdeg_waddr = clr32[CAW-1:0];
            cdeg_wdata = '0;
            vdeg_wdata = '0;
         end
         default: begin
            busy = 1'b1;
         end
      endcase
   end

   // Configuration registers.
   always_comb begin
      num_checks_in    = num_checks_ff;
      num_variables_in = num_variables_ff;
      if (csr_we) begin
         case (csr_type'(csr_index))
            CSR_NUM_CHECKS:    num_checks_in    = csr_wdata[NCHK_W-1:0];
            CSR_NUM_VARIABLES: num_variables_in = csr_wdata[NVAR_W-1:0];
            default:           num_checks_in    = num_checks_ff;
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff         <= ST_CLEAR;
         clr_cnt_ff       <= '0;
         rsp_valid_ff     <= 1'b0;
         num_checks_ff    <= NUM_CHECKS_RST;
         num_variables_ff <= NUM_VARIABLES_RST;
      end else begin
         state_ff         <= state_in;
         clr_cnt_ff       <= clr_cnt_in;
         rsp_valid_ff     <= rsp_valid_in;
         num_checks_ff    <= num_checks_in;
         num_variables_ff <= num_variables_in;
      end
   end

   always_ff @(posedge clock) begin
      if (state_ff == ST_IDLE && start) begin
         op_ff   <= op_type'(req_op);
         row_ff  <= req_row;
         col_ff  <= req_col;
         bit_ff  <= req_bit_req;
         slot_ff <= req_slot;
      end
      if (state_ff == ST_EXEC) begin
         rsp_neighbor_ff <= rsp_neighbor_in;
         rsp_cdeg_ff     <= rsp_cdeg_in;
         rsp_vdeg_ff     <= rsp_vdeg_in;
         rsp_error_ff    <= rsp_error_in;
      end
   end

   assign rsp_valid           = rsp_valid_ff;
   assign rsp_neighbor        = rsp_neighbor_ff;
   assign rsp_check_degree    = rsp_cdeg_ff;
   assign rsp_variable_degree = rsp_vdeg_ff;
   assign rsp_error           = rsp_error_ff;

endmodule

>>> sv/tgab_ram.sv
// ----------------------------------------------------------------------------
// Tanner graph adjacency builder RAM
// Simple dual-port synchronous RAM with one write port and a registered read.
// ----------------------------------------------------------------------------
module tgab_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 256,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic             clock,
   input  logic             we,
   input  logic [AW-1:0]    waddr,
   input  logic [WIDTH-1:0] wdata,
   input  logic [AW-1:0]    raddr,
   output logic [WIDTH-1:0] rdata
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      rdata_ff <= mem[raddr];
   end

   assign rdata = rdata_ff;

endmodule

>>> test/tanner_graph_adjacency_builder_core_test.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Tanner graph adjacency builder core test
// Streams parity-check entries, list reads and clears into the core under
// several size settings. A scoreboard keeps its own copy of the neighbor
// lists and degrees, and checks each response field by field.
// ----------------------------------------------------------------------------
module tanner_graph_adjacency_builder_core_test;

   import tgab_pkg::*;

   localparam int RANDOM_ITEMS = 850;
   localparam int CALM_AFTER   = 740;
   localparam int STALL_LIMIT  = 4000;

   typedef struct {
      op_type              op;
      logic [ROW_W-1:0]    row;
      logic [COL_W-1:0]    col;
      logic                entry_bit;
      logic [SLOT_W-1:0]   slot;
   } item_type;

   typedef struct {
      logic [NEIGHBOR_W-1:0] neighbor;
      logic [CDEG_W-1:0]     check_degree;
      logic [VDEG_W-1:0]     variable_degree;
      err_type               err;
   } result_type;

   class adjacency_scoreboard_type;
      logic [NEIGHBOR_W-1:0] check_lists [MAX_ROWS_DEF][CHECK_DEGREE_LIMIT_DEF];
      logic [CDEG_W-1:0]     check_degrees [MAX_ROWS_DEF];
      logic [ROW_W-1:0]      variable_lists [MAX_COLS_DEF][VARIABLE_DEGREE_LIMIT_DEF];
      logic [VDEG_W-1:0]     variable_degrees [MAX_COLS_DEF];
      int unsigned           num_checks;
      int unsigned           num_variables;
      result_type            expected_results[$];
      int                    errors;
      int                    accepted;
      int                    err_seen[5];

      function new();
         num_checks = NUM_CHECKS_RST;
         num_variables = NUM_VARIABLES_RST;
         foreach (check_degrees[i]) check_degrees[i] = '0;
         foreach (variable_degrees[i]) variable_degrees[i] = '0;
         foreach (check_lists[i, j]) check_lists[i][j] = '0;
         foreach (variable_lists[i, j]) variable_lists[i][j] = '0;
         foreach (err_seen[i]) err_seen[i] = 0;
         errors = 0;
         accepted = 0;
      endfunction

      function void set_register(csr_type index, logic [CSR_DATA_W-1:0] data);
         if (index == CSR_NUM_CHECKS)
            num_checks = data[NCHK_W-1:0];
         else
            num_variables = data[NVAR_W-1:0];
      endfunction

      function int unsigned row_limit();
         return (num_checks < MAX_ROWS_DEF) ? num_checks : MAX_ROWS_DEF;
      endfunction

      function int unsigned col_limit();
         return (num_variables < MAX_COLS_DEF) ? num_variables : MAX_COLS_DEF;
      endfunction

      function result_type update_graph(item_type it);
         result_type        res;
         logic              row_ok;
         logic              col_ok;
         logic [CDEG_W-1:0] cd;
         logic [VDEG_W-1:0] vd;
         row_ok = it.row < row_limit();
         col_ok = it.col < col_limit();
         cd = check_degrees[it.row];
         vd = variable_degrees[it.col];
         res.neighbor = '0;
         res.err = ERR_NONE;
         case (it.op)
            OP_ENTRY: begin
               if (!row_ok || !col_ok) begin
                  res.err = ERR_RANGE;
               end else if (it.entry_bit) begin
                  if (cd >= CHECK_DEGREE_LIMIT_DEF) begin
                     res.err = ERR_CHECK_FULL;
                  end else if (vd >= VARIABLE_DEGREE_LIMIT_DEF) begin
                     res.err = ERR_VAR_FULL;
                  end else begin
                     check_lists[it.row][cd] = it.col;
                     variable_lists[it.col][vd] = it.row;
                     check_degrees[it.row] = cd + 1'b1;
                     variable_degrees[it.col] = vd + 1'b1;
                  end
               end
            end
            OP_READ_CHECK: begin
               if (!row_ok)
                  res.err = ERR_RANGE;
               else if (it.slot >= cd)
                  res.err = ERR_SLOT;
               else
                  res.neighbor = check_lists[it.row][it.slot];
            end
            OP_READ_VAR: begin
               if (!col_ok)
                  res.err = ERR_RANGE;
               else if (it.slot >= vd)
                  res.err = ERR_SLOT;
               else
                  res.neighbor = NEIGHBOR_W'(variable_lists[it.col][it.slot]);
            end
            default: begin
               foreach (check_degrees[i]) check_degrees[i] = '0;
               foreach (variable_degrees[i]) variable_degrees[i] = '0;
            end
         endcase
         res.check_degree = row_ok ? check_degrees[it.row] : '0;
         res.variable_degree = col_ok ? variable_degrees[it.col] : '0;
         return res;
      endfunction

      function void note(item_type it);
         result_type res;
         res = update_graph(it);
         err_seen[res.err]++;
         accepted++;
         expected_results.push_back(res);
      endfunction

      task report(string msg);
         $display("MISMATCH at %0t: %s", $realtime, msg);
         errors++;
      endtask

      task check(result_type got);
         result_type want;
         if (expected_results.size() == 0) begin
            report("response with no transaction outstanding");
         end else begin
            want = expected_results.pop_front();
            if (got.neighbor !== want.neighbor)
               report($sformatf("neighbor %0d, expected %0d", got.neighbor, want.neighbor));
            if (got.check_degree !== want.check_degree)
               report($sformatf("check_degree %0d, expected %0d",
                                got.check_degree, want.check_degree));
            if (got.variable_degree !== want.variable_degree)
               report($sformatf("variable_degree %0d, expected %0d",
                                got.variable_degree, want.variable_degree));
            if (got.err !== want.err)
               report($sformatf("error %0d, expected %0d", got.err, want.err));
         end
      endtask
   endclass

   logic                  clock;
   logic                  reset;
   logic                  start;
   logic                  busy;
   logic [OP_W-1:0]       req_op;
   logic [ROW_W-1:0]      req_row;
   logic [COL_W-1:0]      req_col;
   logic                  req_bit_req;
   logic [SLOT_W-1:0]     req_slot;
   logic                  rsp_valid;
   logic [NEIGHBOR_W-1:0] rsp_neighbor;
   logic [CDEG_W-1:0]     rsp_check_degree;
   logic [VDEG_W-1:0]     rsp_variable_degree;
   logic [ERROR_W-1:0]    rsp_error;
   logic                  csr_we;
   logic [CSR_IDX_W-1:0]  csr_index;
   logic [CSR_DATA_W-1:0] csr_wdata;

   adjacency_scoreboard_type graph_board = new();
   int issued = 0;
   int idle_rate = 0;
   int size_settings = 0;

   tanner_graph_adjacency_builder_core uut (
      .clock(clock),
      .reset(reset),
      .start(start),
      .busy(busy),
      .req_op(req_op),
      .req_row(req_row),
      .req_col(req_col),
      .req_bit_req(req_bit_req),
      .req_slot(req_slot),
      .rsp_valid(rsp_valid),
      .rsp_neighbor(rsp_neighbor),
      .rsp_check_degree(rsp_check_degree),
      .rsp_variable_degree(rsp_variable_degree),
      .rsp_error(rsp_error),
      .csr_we(csr_we),
      .csr_index(csr_index),
      .csr_wdata(csr_wdata)
   );

   initial begin
      clock = 1'b0;
      forever #5 clock = ~clock;
   end

   always @(posedge clock) begin : monitor
      item_type   seen_item;
      result_type seen_result;
      if (!reset) begin
         if (start && !busy) begin
            seen_item.op = op_type'(req_op);
            seen_item.row = req_row;
            seen_item.col = req_col;
            seen_item.entry_bit = req_bit_req;
            seen_item.slot = req_slot;
            graph_board.note(seen_item);
         end
         if (rsp_valid) begin
            seen_result.neighbor = rsp_neighbor;
            seen_result.check_degree = rsp_check_degree;
            seen_result.variable_degree = rsp_variable_degree;
            seen_result.err = err_type'(rsp_error);
            graph_board.check(seen_result);
         end
      end
   end

   initial begin : watchdog
      int quiet_cycles;
      quiet_cycles = 0;
      while (quiet_cycles < STALL_LIMIT) begin
         @(posedge clock);
         if ((start && !busy) || rsp_valid)
            quiet_cycles = 0;
         else
            quiet_cycles++;
      end
      $display("Timeout: no transaction for %0d cycles.", STALL_LIMIT);
      $display("DONE: errors detected");
      $finish;
   end

   // Called just after the clock rises; returns once the core has taken the
   // transaction, with start still high.
   task automatic issue(input op_type op, input int row, input int col,
                        input int entry_bit, input int slot);
      if (issued < CALM_AFTER && $urandom_range(0, 7) < idle_rate) begin
         start <= 1'b0;
         repeat ($urandom_range(1, 14)) @(posedge clock);
      end
      start <= 1'b1;
      req_op <= op;
      req_row <= ROW_W'(row);
      req_col <= COL_W'(col);
      req_bit_req <= entry_bit[0];
      req_slot <= SLOT_W'(slot);
      do @(posedge clock); while (busy);
      issued++;
   endtask

   task automatic settle();
      start <= 1'b0;
      repeat (2) @(posedge clock);
      while (graph_board.expected_results.size() != 0) @(posedge clock);
   endtask

   task automatic write_sizes(input logic [CSR_DATA_W-1:0] checks_word,
                              input logic [CSR_DATA_W-1:0] vars_word);
      csr_we <= 1'b1;
      csr_index <= CSR_NUM_CHECKS;
      csr_wdata <= checks_word;
      @(posedge clock);
      csr_index <= CSR_NUM_VARIABLES;
      csr_wdata <= vars_word;
      @(posedge clock);
      csr_we <= 1'b0;
      graph_board.set_register(CSR_NUM_CHECKS, checks_word);
      graph_board.set_register(CSR_NUM_VARIABLES, vars_word);
      size_settings++;
   endtask

   task automatic issue_noise();
      op_type op;
      op = ($urandom_range(0, 19) == 0) ? OP_CLEAR : op_type'($urandom_range(0, 2));
      issue(op, $urandom_range(0, 255), $urandom_range(0, 511), $urandom_range(0, 1),
            $urandom_range(0, 15));
   endtask

   initial begin : stimulus
      int nc;
      int nv;
      int rows_used;
      int cols_used;
      int row_base;
      int col_base;
      int density;
      int n;
      start = 1'b0;
      reset = 1'b1;
      req_op = OP_ENTRY;
      req_row = '0;
      req_col = '0;
      req_bit_req = 1'b0;
      req_slot = '0;
      csr_we = 1'b0;
      csr_index = CSR_NUM_CHECKS;
      csr_wdata = '0;
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      // Reset sizes: full index range, list extremes, unused slots, clear.
      size_settings = 1;
      issue(OP_ENTRY, 0, 0, 0, 0);
      issue(OP_ENTRY, 0, 0, 1, 0);
      issue(OP_ENTRY, 0, 511, 1, 0);
      issue(OP_ENTRY, 255, 0, 1, 0);
      issue(OP_ENTRY, 255, 511, 1, 15);
      issue(OP_READ_CHECK, 0, 0, 0, 0);
      issue(OP_READ_CHECK, 0, 0, 0, 1);
      issue(OP_READ_CHECK, 0, 0, 0, 15);
      issue(OP_READ_VAR, 0, 511, 0, 1);
      issue(OP_READ_VAR, 0, 0, 0, 2);
      issue(OP_READ_CHECK, 255, 511, 1, 1);
      issue(OP_CLEAR, 255, 511, 1, 15);
      issue(OP_READ_CHECK, 0, 0, 0, 0);
      settle();

      // Small sizes put the upper indexes out of range.
      write_sizes(10'h203, 10'd5);
      issue(OP_ENTRY, 3, 0, 1, 0);
      issue(OP_ENTRY, 0, 5, 1, 0);
      issue(OP_ENTRY, 3, 5, 0, 0);
      issue(OP_READ_CHECK, 3, 0, 0, 0);
      issue(OP_READ_VAR, 0, 5, 0, 0);
      issue(OP_READ_CHECK, 0, 9, 0, 0);
      issue(OP_ENTRY, 2, 4, 1, 0);
      settle();

      write_sizes('0, '0);
      issue(OP_ENTRY, 0, 0, 1, 0);
      issue(OP_READ_CHECK, 0, 0, 0, 0);
      issue(OP_CLEAR, 0, 0, 0, 0);
      settle();

      issued = 0;
      while (issued < RANDOM_ITEMS) begin
         case ($urandom_range(0, 9))
            0: nc = 0;
            1: nc = 1;
            2: nc = 255;
            3: nc = 256;
            4: nc = 511;
            default: nc = $urandom_range(2, 40);
         endcase
         case ($urandom_range(0, 9))
            0: nv = 0;
            1: nv = 1;
            2: nv = 511;
            3: nv = 512;
            4: nv = 1023;
            default: nv = $urandom_range(2, 60);
         endcase
         write_sizes({1'($urandom_range(0, 1)), 9'(nc)}, 10'(nv));
         idle_rate = $urandom_range(0, 3);
         if (graph_board.row_limit() > 0 && graph_board.col_limit() > 0 &&
             $urandom_range(0, 9) < 8) begin
            if ($urandom_range(0, 3) != 0)
               issue(OP_CLEAR, $urandom_range(0, 255), $urandom_range(0, 511), 0, 0);
            rows_used = $urandom_range(1, 12);
            cols_used = $urandom_range(1, 24);
            if (rows_used > graph_board.row_limit()) rows_used = graph_board.row_limit();
            if (cols_used > graph_board.col_limit()) cols_used = graph_board.col_limit();
            row_base = $urandom_range(0, graph_board.row_limit() - rows_used);
            col_base = $urandom_range(0, graph_board.col_limit() - cols_used);
            density = $urandom_range(10, 95);
            for (int r = 0; r < rows_used; r++)
               for (int c = 0; c < cols_used; c++)
                  issue(OP_ENTRY, row_base + r, col_base + c,
                        $urandom_range(0, 99) < density, $urandom_range(0, 15));
            n = $urandom_range(8, 30);
            repeat (n) begin
               if ($urandom_range(0, 1) == 0)
                  issue(OP_READ_CHECK, row_base + $urandom_range(0, rows_used - 1),
                        $urandom_range(0, 511), $urandom_range(0, 1),
                        $urandom_range(0, 15));
               else
                  issue(OP_READ_VAR, $urandom_range(0, 255),
                        col_base + $urandom_range(0, cols_used - 1),
                        $urandom_range(0, 1), $urandom_range(0, 9));
            end
            repeat ($urandom_range(0, 4)) issue_noise();
         end else begin
            repeat ($urandom_range(20, 40)) issue_noise();
         end
         settle();
      end

      repeat (8) @(posedge clock);
      $display("Checked %0d transactions across %0d size settings.",
               graph_board.accepted, size_settings);
      $display("Error responses: range %0d, check full %0d, variable full %0d, slot %0d.",
               graph_board.err_seen[ERR_RANGE], graph_board.err_seen[ERR_CHECK_FULL],
               graph_board.err_seen[ERR_VAR_FULL], graph_board.err_seen[ERR_SLOT]);
      if (graph_board.errors == 0)
         $display("DONE: 0 errors");
      else
         $display("DONE: errors detected");
      $finish;
   end

endmodule

>>> filelist.f
sv/tgab_pkg.sv
sv/tgab_ram.sv
sv/tanner_graph_adjacency_builder_core.sv
test/tanner_graph_adjacency_builder_core_test.sv
